>>> rtl/core/i2p_pkg.sv
// Shared types, codes and helper functions for the infix to postfix converter.
`timescale 1ns / 1ps
package i2p_pkg;

  // Input token kinds; code 7 carries no meaning and is ignored
  typedef enum logic [2:0] {
    TK_NUMBER   = 3'd0,
    TK_VARIABLE = 3'd1,
    TK_BINARY   = 3'd2,
    TK_FUNCTION = 3'd3,
    TK_LPAREN   = 3'd4,
    TK_RPAREN   = 3'd5,
    TK_END      = 3'd6
  } tok_kind_t;

  // Operator codes that mark priority and output kind boundaries
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_SIN = 3'd5;

  // Operator priorities
  localparam logic [1:0] PRIO_ADD = 2'd0;
  localparam logic [1:0] PRIO_MUL = 2'd1;
  localparam logic [1:0] PRIO_POW = 2'd3;

  // Result kinds
  localparam logic [1:0] RK_NUMBER   = 2'd0;
  localparam logic [1:0] RK_VARIABLE = 2'd1;
  localparam logic [1:0] RK_BINARY   = 2'd2;
  localparam logic [1:0] RK_FUNCTION = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_FULL      = 2'd1;
  localparam logic [1:0] ERR_UNMATCHED = 2'd2;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [2:0]  operator_code;
    logic [4:0]  variable_letter;
    logic [31:0] number_word;
  } in_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [2:0]  out_operator;
    logic [4:0]  out_letter;
    logic [31:0] out_number;
    logic [1:0]  error_code;
    logic        last_of_run;
  } out_t;

  // One stack entry: an operator, or an explicit left parenthesis when is_op is clear
  typedef struct packed {
    logic       is_op;
    logic [2:0] code;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAF,
    ST_OP_POP,
    ST_LPAREN,
    ST_RPAREN,
    ST_END_POP
  } state_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_LEAF,
    EMIT_TOP,
    EMIT_ERR_FULL,
    EMIT_ERR_UNMATCHED
  } emit_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  load;
    emit_t emit;
    logic  last;
    logic  pop;
    logic  push_op;
    logic  push_paren;
    logic  paren_dec;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [2:0] in_kind;
    logic       empty;
    logic       full;
    logic       no_paren;
    logic       top_is_op;
    logic       pop_ok;
    logic       pop_last;
    logic       rp_last;
    logic       end_last;
    logic       slot_free;
  } dp_stat_t;

  function automatic logic [1:0] op_prio(input logic [2:0] code);
    logic [1:0] p;
    if (code <= OP_SUB) begin
      p = PRIO_ADD;
    end else if (code <= OP_DIV) begin
      p = PRIO_MUL;
    end else begin
      p = PRIO_POW;
    end
    return p;
  endfunction

  function automatic logic [1:0] op_kind(input logic [2:0] code);
    return (code >= OP_SIN) ? RK_FUNCTION : RK_BINARY;
  endfunction

endpackage

>>> rtl/core/i2p_ctrl.sv
// Controller state machine that sequences token handling and stack pops.
`timescale 1ns / 1ps
module i2p_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               tok_valid,
  output logic               tok_ready,
  input  i2p_pkg::dp_stat_t  stat,
  output i2p_pkg::dp_cmd_t   cmd
);
  import i2p_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit   = EMIT_NONE;
    tok_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        tok_ready = 1'b1;
        if (tok_valid) begin
          cmd.load = 1'b1;
          unique case (stat.in_kind)
            TK_NUMBER, TK_VARIABLE: state_next = ST_LEAF;
            TK_BINARY, TK_FUNCTION: state_next = ST_OP_POP;
            TK_LPAREN:              state_next = ST_LPAREN;
            TK_RPAREN:              state_next = ST_RPAREN;
            TK_END:                 state_next = ST_END_POP;
            default:                state_next = ST_IDLE;
          endcase
        end
      end
      ST_LEAF: begin
        if (stat.slot_free) begin
          cmd.emit   = EMIT_LEAF;
          state_next = ST_IDLE;
        end
      end
      // Pop operators of equal or higher priority, then push, or report a full stack
      ST_OP_POP: begin
        if (stat.pop_ok) begin
          if (stat.slot_free) begin
            cmd.emit = EMIT_TOP;
            cmd.last = stat.pop_last;
            cmd.pop  = 1'b1;
          end
        end else if (stat.full) begin
          if (stat.slot_free) begin
            cmd.emit   = EMIT_ERR_FULL;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.push_op = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_LPAREN: begin
        if (stat.full) begin
          if (stat.slot_free) begin
            cmd.emit   = EMIT_ERR_FULL;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.push_paren = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      // Drain down to the matching left parenthesis and drop it; report an unmatched error if none is open
      ST_RPAREN: begin
        if (stat.no_paren) begin
          if (stat.slot_free) begin
            cmd.emit   = EMIT_ERR_UNMATCHED;
            state_next = ST_IDLE;
          end
        end else if (stat.top_is_op) begin
          if (stat.slot_free) begin
            cmd.emit = EMIT_TOP;
            cmd.last = stat.rp_last;
            cmd.pop  = 1'b1;
          end
        end else begin
          cmd.pop       = 1'b1;
          cmd.paren_dec = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      // Empty the whole stack, dropping unclosed parentheses silently
      ST_END_POP: begin
        if (stat.empty) begin
          state_next = ST_IDLE;
        end else if (stat.top_is_op) begin
          if (stat.slot_free) begin
            cmd.emit = EMIT_TOP;
            cmd.last = stat.end_last;
            cmd.pop  = 1'b1;
          end
        end else begin
          cmd.pop       = 1'b1;
          cmd.paren_dec = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/i2p_dpath.sv
// Datapath: token register, operator stack memory with cached top entries, result register.
`timescale 1ns / 1ps
module i2p_dpath #(
  parameter int STACK_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  i2p_pkg::in_t      tok_data,
  input  i2p_pkg::dp_cmd_t  cmd,
  output i2p_pkg::dp_stat_t stat,
  output logic              res_valid,
  input  logic              res_ready,
  output i2p_pkg::out_t     res_data
);
  import i2p_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_ZERO = CNT_W'(0);
  localparam logic [CNT_W-1:0] CNT_3    = CNT_W'(3);

  in_t              tok;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] paren_cnt;
  entry_t           top;
  entry_t           second;
  entry_t           mem [STACK_DEPTH];
  entry_t           new_entry;
  logic [CNT_W-1:0] cnt_m3;
  logic [CNT_W-1:0] op_cnt;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;
  logic [1:0]       pr;
  logic             push;
  out_t             res_next;

  assign pr        = op_prio(tok.operator_code);
  assign push      = cmd.push_op | cmd.push_paren;
  assign new_entry = '{is_op: cmd.push_op, code: cmd.push_op ? tok.operator_code : 3'd0};
  assign cnt_m3    = cnt - CNT_3;
  assign rd_idx    = cnt_m3[IDX_W-1:0];
  assign wr_idx    = cnt[IDX_W-1:0];
  assign op_cnt    = cnt - paren_cnt;

  // Hold the accepted token
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tok <= tok_data;
    end
  end

  // Stack and parenthesis counts
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= CNT_ZERO;
      paren_cnt <= CNT_ZERO;
    end else begin
      if (cmd.pop) begin
        cnt <= cnt - CNT_ONE;
      end else if (push) begin
        cnt <= cnt + CNT_ONE;
      end
      if (cmd.push_paren) begin
        paren_cnt <= paren_cnt + CNT_ONE;
      end else if (cmd.paren_dec) begin
        paren_cnt <= paren_cnt - CNT_ONE;
      end
    end
  end

  // Stack memory write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_idx] <= new_entry;
    end
  end

  // Keep the two top entries in registers; refill the second one from memory on a pop
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      top    <= second;
      second <= mem[rd_idx];
    end else if (push) begin
      second <= top;
      top    <= new_entry;
    end
  end

  // Status towards the controller
  always_comb begin
    stat.in_kind   = tok_data.token_kind;
    stat.empty     = (cnt == CNT_ZERO);
    stat.full      = (cnt == CNT_FULL);
    stat.no_paren  = (paren_cnt == CNT_ZERO);
    stat.top_is_op = top.is_op;
    stat.pop_ok    = (cnt != CNT_ZERO) && top.is_op && (op_prio(top.code) >= pr);
    stat.pop_last  = !((cnt > CNT_ONE) && second.is_op && (op_prio(second.code) >= pr));
    stat.rp_last   = !second.is_op;
    stat.end_last  = (op_cnt == CNT_ONE);
    stat.slot_free = !res_valid || res_ready;
  end

  // Build the result beat
  always_comb begin
    res_next = '0;
    unique case (cmd.emit)
      EMIT_LEAF: begin
        res_next.last_of_run = 1'b1;
        if (tok.token_kind == TK_NUMBER) begin
          res_next.out_kind   = RK_NUMBER;
          res_next.out_number = tok.number_word;
        end else begin
          res_next.out_kind   = RK_VARIABLE;
          res_next.out_letter = tok.variable_letter;
        end
      end
      EMIT_TOP: begin
        res_next.out_kind     = op_kind(top.code);
        res_next.out_operator = top.code;
        res_next.last_of_run  = cmd.last;
      end
      EMIT_ERR_FULL: begin
        res_next.error_code  = ERR_FULL;
        res_next.last_of_run = 1'b1;
      end
      EMIT_ERR_UNMATCHED: begin
        res_next.error_code  = ERR_UNMATCHED;
        res_next.last_of_run = 1'b1;
      end
      default: res_next.error_code = ERR_OK;
    endcase
  end

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (cmd.emit != EMIT_NONE) begin
      res_data <= res_next;
    end
  end

endmodule

>>> rtl/core/infix_to_postfix_converter_core.sv
// Top level of the shunting-yard infix to postfix token converter.
// Channel | Direction | Handshake            | Payload
// tok     | in        | tok_valid/tok_ready  | tok_data  (i2p_pkg::in_t, one token)
// res     | out       | res_valid/res_ready  | res_data  (i2p_pkg::out_t, one postfix token)
// Steps: each token is accepted in ST_IDLE and handled in its own state, which emits a leaf or an
// error beat, pushes an operator or left parenthesis after any pops, or pops entries for a right
// parenthesis or end marker; an unused token kind is accepted in ST_IDLE and dropped.
// One pop per cycle unless stalled is set by the single registered read port of the stack.
// Reset clears the stack count; stack memory needs no clearing pass.
// A stalled result holds in the output register and stalls only the next emitting step.
`timescale 1ns / 1ps
module infix_to_postfix_converter_core #(
  parameter int STACK_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          tok_valid,
  output logic          tok_ready,
  input  i2p_pkg::in_t  tok_data,
  output logic          res_valid,
  input  logic          res_ready,
  output i2p_pkg::out_t res_data
);
  import i2p_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  i2p_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Stack and result datapath
  i2p_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .tok_data  (tok_data),
    .cmd       (cmd),
    .stat      (stat),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule

>>> rtl/core/i2p_checker.sv
// Port-level checks for the infix to postfix converter and their bind.
`timescale 1ns / 1ps
module i2p_checker (
  input logic          clk,
  input logic          rst,
  input logic          res_valid,
  input logic          res_ready,
  input i2p_pkg::out_t res_data
);
  import i2p_pkg::*;

  // A waiting result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result beat changed while stalled");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // An error beat is alone in its run and carries no token
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.error_code != ERR_OK) |->
      res_data.last_of_run && (res_data.out_kind == RK_NUMBER) &&
      (res_data.out_number == 32'd0) && (res_data.out_operator == 3'd0))
    else $error("malformed error beat");

  // A number or variable is the only beat of its run
  a_leaf_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.error_code == ERR_OK) &&
      ((res_data.out_kind == RK_NUMBER) || (res_data.out_kind == RK_VARIABLE)) |->
      res_data.last_of_run)
    else $error("leaf beat not marked last");

  // Operator beats carry no letter or number bits
  a_op_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && ((res_data.out_kind == RK_BINARY) || (res_data.out_kind == RK_FUNCTION)) |->
      (res_data.out_letter == 5'd0) && (res_data.out_number == 32'd0))
    else $error("operator beat carries stray payload");

endmodule

bind infix_to_postfix_converter_core i2p_checker u_i2p_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_data  (res_data)
);

>>> tb/sv/postfix_stream_checker.sv
// Checker for the infix to postfix converter: tracks token beats, predicts postfix output, compares.
`timescale 1ns / 1ps
module postfix_stream_checker #(
  parameter int STACK_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          tok_valid,
  input  logic          tok_ready,
  input  i2p_pkg::in_t  tok_data,
  input  logic          res_valid,
  input  logic          res_ready,
  input  i2p_pkg::out_t res_data,
  input  logic          all_done,
  output int            fail_count,
  output int            pending_count,
  output int            token_count,
  output int            result_count,
  output int            error_count
);
  import i2p_pkg::*;

  localparam int         REPORT_LIMIT = 10;
  localparam int         OP_FLAG      = 3;
  localparam logic [3:0] PAREN_ENTRY  = 4'b0000;

  // Shadow operator stack; bit 3 marks an operator, clear marks a left parenthesis
  logic [3:0] op_stack [0:STACK_DEPTH-1];
  int         stack_fill;
  out_t       postfix_q [$];
  bit         leftover_checked;

  initial begin
    fail_count       = 0;
    pending_count    = 0;
    token_count      = 0;
    result_count     = 0;
    error_count      = 0;
    stack_fill       = 0;
    leftover_checked = 0;
  end

  function automatic logic [1:0] rank_of(input logic [2:0] code);
    if (code > OP_DIV) begin
      return PRIO_POW;
    end
    return (code > OP_SUB) ? PRIO_MUL : PRIO_ADD;
  endfunction

  function automatic out_t operator_token(input logic [2:0] code);
    out_t r;
    r              = '0;
    r.out_kind     = (code < OP_SIN) ? RK_BINARY : RK_FUNCTION;
    r.out_operator = code;
    return r;
  endfunction

  function automatic out_t error_token(input logic [1:0] err);
    out_t r;
    r             = '0;
    r.error_code  = err;
    r.last_of_run = 1'b1;
    return r;
  endfunction

  // Work out the postfix tokens that one accepted input token releases
  task automatic predict_postfix(input in_t t);
    out_t run_q [$];
    out_t r;
    int   scan;
    bit   found;
    bit   failed;
    logic [1:0] rank;
    run_q.delete();
    failed = 0;
    r      = '0;
    case (t.token_kind)
      TK_NUMBER: begin
        r.out_kind   = RK_NUMBER;
        r.out_number = t.number_word;
        run_q.push_back(r);
      end
      TK_VARIABLE: begin
        r.out_kind   = RK_VARIABLE;
        r.out_letter = t.variable_letter;
        run_q.push_back(r);
      end
      TK_BINARY, TK_FUNCTION: begin
        rank = rank_of(t.operator_code);
        // Pop operators of equal or higher rank down to a parenthesis
        while (stack_fill > 0 && op_stack[stack_fill-1][OP_FLAG] &&
               rank_of(op_stack[stack_fill-1][2:0]) >= rank) begin
          run_q.push_back(operator_token(op_stack[stack_fill-1][2:0]));
          stack_fill--;
        end
        if (stack_fill >= STACK_DEPTH) begin
          failed = 1;
        end else begin
          op_stack[stack_fill] = {1'b1, t.operator_code};
          stack_fill++;
        end
        if (failed) begin
          run_q.delete();
          run_q.push_back(error_token(ERR_FULL));
        end
      end
      TK_LPAREN: begin
        if (stack_fill >= STACK_DEPTH) begin
          run_q.push_back(error_token(ERR_FULL));
        end else begin
          op_stack[stack_fill] = PAREN_ENTRY;
          stack_fill++;
        end
      end
      TK_RPAREN: begin
        scan  = stack_fill;
        found = 0;
        while (scan > 0 && !found) begin
          if (!op_stack[scan-1][OP_FLAG]) begin
            found = 1;
          end else begin
            scan--;
          end
        end
        if (!found) begin
          run_q.push_back(error_token(ERR_UNMATCHED));
        end else begin
          // Release everything above the matching parenthesis, then drop it
          while (stack_fill > scan) begin
            run_q.push_back(operator_token(op_stack[stack_fill-1][2:0]));
            stack_fill--;
          end
          stack_fill--;
        end
      end
      TK_END: begin
        // Flush operators; unclosed parentheses vanish quietly
        while (stack_fill > 0) begin
          if (op_stack[stack_fill-1][OP_FLAG]) begin
            run_q.push_back(operator_token(op_stack[stack_fill-1][2:0]));
          end
          stack_fill--;
        end
      end
      default: begin
      end
    endcase
    if (run_q.size() > 0) begin
      run_q[run_q.size()-1].last_of_run = 1'b1;
    end
    foreach (run_q[i]) begin
      postfix_q.push_back(run_q[i]);
    end
  endtask

  // Compare one result beat against the oldest prediction
  task automatic check_postfix(input out_t got);
    out_t want;
    result_count++;
    if (got.error_code != ERR_OK) begin
      error_count++;
    end
    if (postfix_q.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
        $display("[%0t] unexpected result beat: kind=%0d op=%0d letter=%0d num=%h err=%0d last=%0b",
                 $realtime, got.out_kind, got.out_operator, got.out_letter, got.out_number,
                 got.error_code, got.last_of_run);
      end
    end else begin
      want = postfix_q.pop_front();
      if (got.out_kind !== want.out_kind || got.out_operator !== want.out_operator ||
          got.out_letter !== want.out_letter || got.out_number !== want.out_number ||
          got.error_code !== want.error_code || got.last_of_run !== want.last_of_run) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $display("[%0t] mismatch: expected kind=%0d op=%0d letter=%0d num=%h err=%0d last=%0b",
                   $realtime, want.out_kind, want.out_operator, want.out_letter,
                   want.out_number, want.error_code, want.last_of_run);
          $display("            actual   kind=%0d op=%0d letter=%0d num=%h err=%0d last=%0b",
                   got.out_kind, got.out_operator, got.out_letter, got.out_number,
                   got.error_code, got.last_of_run);
        end
      end
    end
  endtask

  // Watch both channels at each rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (tok_valid && tok_ready) begin
        token_count++;
        predict_postfix(tok_data);
      end
      if (res_valid && res_ready) begin
        check_postfix(res_data);
      end
      if (all_done && !leftover_checked) begin
        leftover_checked = 1;
        if (postfix_q.size() != 0) begin
          fail_count += postfix_q.size();
          $display("[%0t] %0d predicted results never arrived", $realtime, postfix_q.size());
        end
      end
      pending_count = postfix_q.size();
    end
  end

endmodule

>>> tb/sv/infix_to_postfix_converter_core_tb.sv
// Testbench top for the infix to postfix converter: clock, reset, token stimulus and verdict.
`timescale 1ns / 1ps
module infix_to_postfix_converter_core_tb;
  import i2p_pkg::*;

  localparam int         STACK_DEPTH   = 64;
  localparam int         ITEMS_PER_PH  = 12;
  localparam int         DRAIN_LIMIT   = 200000;
  localparam int         SETTLE_CYCLES = 40;
  localparam logic [2:0] KIND_UNUSED   = 3'd7;
  localparam logic [2:0] OP_ADD        = 3'd0;
  localparam logic [2:0] OP_MUL        = 3'd2;
  localparam logic [2:0] OP_POW        = 3'd4;
  localparam logic [2:0] OP_COS        = 3'd6;
  localparam logic [2:0] OP_TAN        = 3'd7;

  logic clk;
  logic rst       = 1'b1;
  logic tok_valid = 1'b0;
  logic tok_ready;
  in_t  tok_data  = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  out_t res_data;
  logic all_done  = 1'b0;

  int fail_count;
  int pending_count;
  int token_count;
  int result_count;
  int error_count;

  int   sender_idle = 0;
  int   recv_stall  = 0;
  int   phase_items = 0;
  in_t  token_plan [$];

  infix_to_postfix_converter_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .tok_valid(tok_valid),
    .tok_ready(tok_ready),
    .tok_data (tok_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

  postfix_stream_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .tok_valid    (tok_valid),
    .tok_ready    (tok_ready),
    .tok_data     (tok_data),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_data     (res_data),
    .all_done     (all_done),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .token_count  (token_count),
    .result_count (result_count),
    .error_count  (error_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Stall the result channel at random, per the current phase
  always @(negedge clk) begin
    res_ready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic in_t make_token(input logic [2:0] kind, input logic [2:0] code,
                                     input logic [4:0] letter, input logic [31:0] number);
    in_t t;
    t.token_kind      = kind;
    t.operator_code   = code;
    t.variable_letter = letter;
    t.number_word     = number;
    return t;
  endfunction

  function automatic in_t random_leaf();
    if ($urandom_range(1) == 0) begin
      return make_token(TK_NUMBER, 3'($urandom_range(7)), 5'($urandom_range(31)), $urandom);
    end
    return make_token(TK_VARIABLE, 3'($urandom_range(7)), 5'($urandom_range(31)), $urandom);
  endfunction

  function automatic in_t random_noise();
    return make_token(3'($urandom_range(7)), 3'($urandom_range(7)), 5'($urandom_range(31)),
                      $urandom);
  endfunction

  function automatic in_t random_operator();
    return make_token($urandom_range(1) ? TK_BINARY : TK_FUNCTION, 3'($urandom_range(7)),
                      5'($urandom_range(31)), $urandom);
  endfunction

  // Present one token beat and hold it until accepted
  task automatic drive_token(input in_t t);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle) begin
      tok_valid <= 1'b0;
      @(negedge clk);
    end
    tok_valid <= 1'b1;
    tok_data  <= t;
    @(posedge clk);
    while (!tok_ready) begin
      @(posedge clk);
    end
    if (t.token_kind != KIND_UNUSED) begin
      phase_items++;
    end
  endtask

  task automatic send_plan();
    while (token_plan.size() > 0) begin
      drive_token(token_plan.pop_front());
    end
  endtask

  task automatic add_token(input logic [2:0] kind, input int unsigned code);
    token_plan.push_back(make_token(kind, 3'(code), 5'($urandom_range(31)), $urandom));
  endtask

  // Build a well-formed operand: leaf, bracketed sub-expression or function call
  task automatic plan_operand(input int nest);
    int pick;
    pick = $urandom_range(9);
    if (nest > 0 && pick >= 5 && pick <= 6) begin
      add_token(TK_LPAREN, $urandom_range(7));
      plan_expression(nest - 1);
      add_token(TK_RPAREN, $urandom_range(7));
    end else if (nest > 0 && pick >= 7) begin
      add_token(TK_FUNCTION, $urandom_range(OP_SIN, OP_TAN));
      if (pick == 9) begin
        plan_operand(nest - 1);
      end else begin
        add_token(TK_LPAREN, $urandom_range(7));
        plan_expression(nest - 1);
        add_token(TK_RPAREN, $urandom_range(7));
      end
    end else begin
      token_plan.push_back(random_leaf());
    end
  endtask

  task automatic plan_expression(input int nest);
    int terms;
    terms = $urandom_range(3);
    plan_operand(nest);
    repeat (terms) begin
      add_token(TK_BINARY, $urandom_range(OP_ADD, OP_POW));
      plan_operand(nest);
    end
  endtask

  // Break a planned expression now and then: drop, stray close or noise beat
  task automatic plan_sentence();
    int spot;
    plan_expression(2);
    if ($urandom_range(99) < 15) begin
      spot = $urandom_range(token_plan.size() - 1);
      case ($urandom_range(2))
        0: token_plan.delete(spot);
        1: token_plan.insert(spot, make_token(TK_RPAREN, 3'($urandom_range(7)),
                                              5'($urandom_range(31)), $urandom));
        default: token_plan.insert(spot, random_noise());
      endcase
    end
    if ($urandom_range(99) < 85) begin
      add_token(TK_END, $urandom_range(7));
    end
  endtask

  // Fill the stack to its limit, then push past it and unwind
  task automatic plan_fill();
    add_token(TK_END, $urandom_range(7));
    repeat (STACK_DEPTH / 2) begin
      add_token(TK_LPAREN, $urandom_range(7));
      token_plan.push_back(random_operator());
    end
    add_token(TK_LPAREN, $urandom_range(7));
    token_plan.push_back(random_operator());
    token_plan.push_back(random_operator());
    repeat (3) begin
      add_token(TK_RPAREN, $urandom_range(7));
    end
    add_token(TK_END, $urandom_range(7));
  endtask

  task automatic plan_directed();
    token_plan.push_back(make_token(TK_RPAREN, OP_ADD, 5'd0, 32'd0));
    token_plan.push_back(make_token(TK_END, OP_ADD, 5'd0, 32'd0));
    token_plan.push_back(make_token(KIND_UNUSED, OP_TAN, 5'd31, 32'hFFFF_FFFF));
    token_plan.push_back(make_token(TK_NUMBER, OP_ADD, 5'd0, 32'd0));
    token_plan.push_back(make_token(TK_NUMBER, OP_TAN, 5'd31, 32'hFFFF_FFFF));
    token_plan.push_back(make_token(TK_VARIABLE, OP_ADD, 5'd0, 32'd0));
    token_plan.push_back(make_token(TK_VARIABLE, OP_TAN, 5'd31, 32'hFFFF_FFFF));
    token_plan.push_back(make_token(TK_BINARY, OP_ADD, 5'd0, 32'd0));
    token_plan.push_back(make_token(TK_VARIABLE, OP_ADD, 5'd25, 32'd0));
    token_plan.push_back(make_token(TK_BINARY, OP_MUL, 5'd0, 32'd0));
    token_plan.push_back(make_token(TK_NUMBER, OP_ADD, 5'd0, 32'h0000_1234));
    token_plan.push_back(make_token(TK_BINARY, OP_POW, 5'd0, 32'd0));
    token_plan.push_back(make_token(TK_VARIABLE, OP_ADD, 5'd3, 32'd0));
    token_plan.push_back(make_token(TK_BINARY, OP_SUB, 5'd0, 32'd0));
    token_plan.push_back(make_token(TK_FUNCTION, OP_SIN, 5'd0, 32'd0));
    token_plan.push_back(make_token(TK_LPAREN, OP_ADD, 5'd0, 32'd0));
    token_plan.push_back(make_token(TK_FUNCTION, OP_COS, 5'd0, 32'd0));
    token_plan.push_back(make_token(TK_BINARY, OP_TAN, 5'd0, 32'd0));
    token_plan.push_back(make_token(TK_VARIABLE, OP_ADD, 5'd23, 32'd0));
    token_plan.push_back(make_token(TK_RPAREN, OP_ADD, 5'd0, 32'd0));
    token_plan.push_back(make_token(TK_FUNCTION, OP_DIV, 5'd0, 32'd0));
    token_plan.push_back(make_token(TK_LPAREN, OP_ADD, 5'd0, 32'd0));
    token_plan.push_back(make_token(TK_VARIABLE, OP_ADD, 5'd1, 32'd0));
    token_plan.push_back(make_token(TK_END, OP_ADD, 5'd0, 32'd0));
  endtask

  initial begin
    int drain_cycles;
    // Hold reset, then release it on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    plan_directed();
    send_plan();

    // Random part over four phases of sender idling and receiver stalls
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle = 0;  recv_stall = 0;  end
        1: begin sender_idle = 73; recv_stall = 0;  end
        2: begin sender_idle = 0;  recv_stall = 73; end
        default: begin sender_idle = 29; recv_stall = 29; end
      endcase
      if (phase == 2) begin
        plan_fill();
        send_plan();
      end
      phase_items = 0;
      while (phase_items < ITEMS_PER_PH) begin
        if ($urandom_range(99) < 10) begin
          token_plan.push_back(random_noise());
        end else begin
          plan_sentence();
        end
        send_plan();
      end
    end
    add_token(TK_END, $urandom_range(7));
    send_plan();

    @(negedge clk);
    tok_valid <= 1'b0;

    // Wait for every predicted result, then let the block settle
    drain_cycles = 0;
    while (pending_count != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      drain_cycles++;
    end
    if (drain_cycles >= DRAIN_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      repeat (SETTLE_CYCLES) @(negedge clk);
      all_done <= 1'b1;
      repeat (2) @(negedge clk);
      $display("Run covered %0d tokens and %0d postfix results (%0d error beats).",
               token_count, result_count, error_count);
      $display("Phases: no idling, sender gaps, receiver stalls, both; stack filled once.");
      if (fail_count == 0) begin
        $display("Simulation PASSED");
      end else begin
        $display("Simulation FAILED");
      end
      $finish;
    end
  end

endmodule

>>> sim.f
rtl/core/i2p_pkg.sv
rtl/core/i2p_ctrl.sv
rtl/core/i2p_dpath.sv
rtl/core/infix_to_postfix_converter_core.sv
rtl/core/i2p_checker.sv
tb/sv/postfix_stream_checker.sv
tb/sv/infix_to_postfix_converter_core_tb.sv
